// ----- hw/rtl/homogeneous_vertex_transform_assert.svh -----
`ifndef HOMOGENEOUS_VERTEX_TRANSFORM_ASSERT_SVH
`define HOMOGENEOUS_VERTEX_TRANSFORM_ASSERT_SVH

// same-cycle implication, disabled during reset
`define HVT_ASSERT_NOW(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("hvt: property violated");

// next-cycle implication, disabled during reset
`define HVT_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("hvt: property violated");

`endif

// ----- hw/rtl/hvt_pkg.sv -----
package hvt_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int LANES     = 4;
	localparam int ENTRIES   = LANES * LANES;
	localparam int IDX_W     = $clog2(ENTRIES);
	localparam int PROD_W    = 2 * DATA_W;
	localparam int SHIFT_W   = PROD_W - FRAC_BITS;
	localparam int SUM_W     = SHIFT_W + 2;

	localparam logic signed [DATA_W-1:0] FX_ONE  = DATA_W'(1) << FRAC_BITS;
	localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_XFORM = 1'b1
	} opcode_t;

	typedef struct packed {
		opcode_t                   opcode;
		logic [IDX_W-1:0]          element_index;
		logic signed [DATA_W-1:0]  element_value;
		logic signed [DATA_W-1:0]  coord_x;
		logic signed [DATA_W-1:0]  coord_y;
		logic signed [DATA_W-1:0]  coord_z;
	} vtx_word_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  out_x;
		logic signed [DATA_W-1:0]  out_y;
		logic signed [DATA_W-1:0]  out_z;
		logic signed [DATA_W-1:0]  out_w;
		logic                      overflow;
	} res_word_t;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
	} lane_ctl_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  value;
		logic                      sat;
	} lane_res_t;

endpackage

// ----- hw/rtl/hvt_lane.sv -----
module hvt_lane (
	input  logic                                clk,
	input  hvt_pkg::lane_ctl_t                  ctl,
	input  logic signed [hvt_pkg::DATA_W-1:0]   m_x,
	input  logic signed [hvt_pkg::DATA_W-1:0]   m_y,
	input  logic signed [hvt_pkg::DATA_W-1:0]   m_z,
	input  logic signed [hvt_pkg::DATA_W-1:0]   m_t,
	input  logic signed [hvt_pkg::DATA_W-1:0]   coord_x,
	input  logic signed [hvt_pkg::DATA_W-1:0]   coord_y,
	input  logic signed [hvt_pkg::DATA_W-1:0]   coord_z,
	output hvt_pkg::lane_res_t                  res
);

	logic signed [hvt_pkg::PROD_W-1:0]  prod_x, prod_y, prod_z;
	logic signed [hvt_pkg::PROD_W-1:0]  p_x_s1, p_y_s1, p_z_s1;
	logic signed [hvt_pkg::DATA_W-1:0]  t_s1;
	logic signed [hvt_pkg::SHIFT_W-1:0] sh_x, sh_y, sh_z;
	logic signed [hvt_pkg::SUM_W-1:0]   sum;
	logic [hvt_pkg::SUM_W-hvt_pkg::DATA_W:0] sum_hi;
	hvt_pkg::lane_res_t                 sat_res;
	hvt_pkg::lane_res_t                 res_s2;

	assign prod_x = m_x * coord_x;
	assign prod_y = m_y * coord_y;
	assign prod_z = m_z * coord_z;

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			p_x_s1 <= prod_x;
			p_y_s1 <= prod_y;
			p_z_s1 <= prod_z;
			t_s1   <= m_t;
		end
	end

	// floor shift: drop the fraction bits of the two's complement product
	assign sh_x = p_x_s1[hvt_pkg::PROD_W-1:hvt_pkg::FRAC_BITS];
	assign sh_y = p_y_s1[hvt_pkg::PROD_W-1:hvt_pkg::FRAC_BITS];
	assign sh_z = p_z_s1[hvt_pkg::PROD_W-1:hvt_pkg::FRAC_BITS];

	assign sum = hvt_pkg::SUM_W'(sh_x) + hvt_pkg::SUM_W'(sh_y)
		+ hvt_pkg::SUM_W'(sh_z) + hvt_pkg::SUM_W'(t_s1);

	assign sum_hi = sum[hvt_pkg::SUM_W-1:hvt_pkg::DATA_W-1];

	always_comb begin
		sat_res.sat   = (sum_hi != '0) && (sum_hi != '1);
		sat_res.value = sum[hvt_pkg::DATA_W-1:0];
		if (sat_res.sat) begin
			sat_res.value = sum[hvt_pkg::SUM_W-1] ? hvt_pkg::SAT_MIN : hvt_pkg::SAT_MAX;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			res_s2 <= sat_res;
		end
	end

	assign res = res_s2;

endmodule

// ----- hw/rtl/hvt_merge.sv -----
module hvt_merge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s2,
	input  hvt_pkg::lane_res_t   lanes [hvt_pkg::LANES],
	output logic                 en_out,
	output logic                 res_valid,
	input  logic                 res_ready,
	output hvt_pkg::res_word_t   res
);

	hvt_pkg::res_word_t merged;
	hvt_pkg::res_word_t res_q;
	logic               res_valid_q;

	always_comb begin
		merged.out_x    = lanes[0].value;
		merged.out_y    = lanes[1].value;
		merged.out_z    = lanes[2].value;
		merged.out_w    = lanes[3].value;
		merged.overflow = 1'b0;
		for (int i = 0; i < hvt_pkg::LANES; i++) begin
			merged.overflow = merged.overflow | lanes[i].sat;
		end
	end

	assign en_out = !res_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en_out) begin
			res_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			res_q <= merged;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ----- hw/rtl/homogeneous_vertex_transform.sv -----
// channel | dir | handshake             | word
// vtx     | in  | vtx_valid / vtx_ready | hvt_pkg::vtx_word_t (write element or point)
// res     | out | res_valid / res_ready | hvt_pkg::res_word_t (x, y, z, w, overflow)
//
// One word per cycle in while vtx_ready is high. A point's result is registered:
// four row lanes multiply in stage 1, shift/add/saturate in stage 2, merge into
// the output register. Element writes land at acceptance and give no result.
// Reset clears the stage valids and loads the identity matrix.
// A stalled output lets the lanes fill; vtx_ready drops with three results held.
module homogeneous_vertex_transform (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vtx_valid,
	output logic                vtx_ready,
	input  hvt_pkg::vtx_word_t  vtx,
	output logic                res_valid,
	input  logic                res_ready,
	output hvt_pkg::res_word_t  res
);

	logic signed [hvt_pkg::DATA_W-1:0] mat_q [hvt_pkg::ENTRIES];
	hvt_pkg::lane_ctl_t                ctl;
	hvt_pkg::lane_res_t                lane_res [hvt_pkg::LANES];
	logic                              valid_s1, valid_s2;
	logic                              en_out;
	logic                              accept;

	assign ctl.en_s2 = !valid_s2 || en_out;
	assign ctl.en_s1 = !valid_s1 || ctl.en_s2;
	assign vtx_ready = ctl.en_s1;
	assign accept    = vtx_valid && vtx_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < hvt_pkg::ENTRIES; i++) begin
				// diagonal: column equals row
				mat_q[i] <= (i[1:0] == i[3:2]) ? hvt_pkg::FX_ONE : '0;
			end
		end else if (accept && vtx.opcode == hvt_pkg::OP_WRITE) begin
			mat_q[vtx.element_index] <= vtx.element_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ctl.en_s1) begin
				valid_s1 <= vtx_valid && vtx.opcode == hvt_pkg::OP_XFORM;
			end
			if (ctl.en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	for (genvar r = 0; r < hvt_pkg::LANES; r++) begin : g_lane
		hvt_lane u_lane (
			.clk     (clk),
			.ctl     (ctl),
			.m_x     (mat_q[r]),
			.m_y     (mat_q[hvt_pkg::LANES + r]),
			.m_z     (mat_q[2 * hvt_pkg::LANES + r]),
			.m_t     (mat_q[3 * hvt_pkg::LANES + r]),
			.coord_x (vtx.coord_x),
			.coord_y (vtx.coord_y),
			.coord_z (vtx.coord_z),
			.res     (lane_res[r])
		);
	end

	hvt_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s2  (valid_s2),
		.lanes     (lane_res),
		.en_out    (en_out),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

// ----- hw/rtl/hvt_checker.sv -----
`include "homogeneous_vertex_transform_assert.svh"

module hvt_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vtx_valid,
	input  logic                vtx_ready,
	input  hvt_pkg::vtx_word_t  vtx,
	input  logic                res_valid,
	input  logic                res_ready,
	input  hvt_pkg::res_word_t  res
);

	logic res_stall;
	logic any_rail;

	assign res_stall = res_valid && !res_ready;
	assign any_rail  = res.out_x == hvt_pkg::SAT_MAX || res.out_x == hvt_pkg::SAT_MIN
		|| res.out_y == hvt_pkg::SAT_MAX || res.out_y == hvt_pkg::SAT_MIN
		|| res.out_z == hvt_pkg::SAT_MAX || res.out_z == hvt_pkg::SAT_MIN
		|| res.out_w == hvt_pkg::SAT_MAX || res.out_w == hvt_pkg::SAT_MIN;

	`HVT_ASSERT_NEXT(a_res_valid_hold, clk, arst_n, res_stall, res_valid)
	`HVT_ASSERT_NEXT(a_res_word_hold, clk, arst_n, res_stall, $stable(res))
	`HVT_ASSERT_NOW(a_ovf_on_rail, clk, arst_n, res_valid && res.overflow, any_rail)
	`HVT_ASSERT_NOW(a_ready_when_drained, clk, arst_n, !res_valid, vtx_ready)

endmodule

bind homogeneous_vertex_transform hvt_checker u_hvt_checker (.*);

// ----- dv/homogeneous_vertex_transform_tb.sv -----
`timescale 1ns / 1ps

module homogeneous_vertex_transform_tb;

	localparam longint ACC_MAX = 64'sd2147483647;
	localparam longint ACC_MIN = -64'sd2147483648;

	class vertex_scoreboard;
		logic signed [hvt_pkg::DATA_W-1:0] matrix [hvt_pkg::ENTRIES];
		hvt_pkg::res_word_t expected_points [$];
		int mismatches;

		function new();
			mismatches = 0;
			for (int i = 0; i < hvt_pkg::ENTRIES; i++)
				matrix[i] = (i % 5 == 0) ? hvt_pkg::FX_ONE : '0;
		endfunction

		function hvt_pkg::res_word_t transform_point(hvt_pkg::vtx_word_t w);
			logic signed [hvt_pkg::DATA_W-1:0] coord [3];
			logic signed [hvt_pkg::DATA_W-1:0] lane [hvt_pkg::LANES];
			longint acc;
			hvt_pkg::res_word_t r;
			coord[0] = w.coord_x;
			coord[1] = w.coord_y;
			coord[2] = w.coord_z;
			r.overflow = 1'b0;
			for (int row = 0; row < hvt_pkg::LANES; row++) begin
				// translation column plus floored products
				acc = longint'(matrix[3*hvt_pkg::LANES + row]);
				for (int col = 0; col < 3; col++)
					acc += (longint'(matrix[col*hvt_pkg::LANES + row]) * longint'(coord[col]))
						>>> hvt_pkg::FRAC_BITS;
				if (acc > ACC_MAX) begin
					acc = ACC_MAX;
					r.overflow = 1'b1;
				end else if (acc < ACC_MIN) begin
					acc = ACC_MIN;
					r.overflow = 1'b1;
				end
				lane[row] = acc[hvt_pkg::DATA_W-1:0];
			end
			r.out_x = lane[0];
			r.out_y = lane[1];
			r.out_z = lane[2];
			r.out_w = lane[3];
			return r;
		endfunction

		function void note_word(hvt_pkg::vtx_word_t w);
			if (w.opcode == hvt_pkg::OP_WRITE)
				matrix[w.element_index] = w.element_value;
			else
				expected_points.push_back(transform_point(w));
		endfunction

		function void flag(string what, logic [hvt_pkg::DATA_W-1:0] want_v,
				logic [hvt_pkg::DATA_W-1:0] got_v);
			if (mismatches < 10)
				$display("%t %s: expected %h got %h", $realtime, what, want_v, got_v);
			mismatches++;
		endfunction

		function void check_result(hvt_pkg::res_word_t got);
			hvt_pkg::res_word_t want;
			if (expected_points.size() == 0) begin
				flag("result word with none pending", '0, got.out_x);
				return;
			end
			want = expected_points.pop_front();
			if (got.out_x !== want.out_x)
				flag("out_x", want.out_x, got.out_x);
			if (got.out_y !== want.out_y)
				flag("out_y", want.out_y, got.out_y);
			if (got.out_z !== want.out_z)
				flag("out_z", want.out_z, got.out_z);
			if (got.out_w !== want.out_w)
				flag("out_w", want.out_w, got.out_w);
			if (got.overflow !== want.overflow)
				flag("overflow", 32'(want.overflow), 32'(got.overflow));
		endfunction

		function int pending();
			return expected_points.size();
		endfunction
	endclass

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               vtx_valid = 1'b0;
	hvt_pkg::vtx_word_t vtx       = '0;
	logic               vtx_ready;
	logic               res_valid;
	logic               res_ready = 1'b0;
	hvt_pkg::res_word_t res;
	logic               quiet     = 1'b0;
	int                 hold_reqs = 0;

	vertex_scoreboard board;

	homogeneous_vertex_transform dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx_valid (vtx_valid),
		.vtx_ready (vtx_ready),
		.vtx       (vtx),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int idle_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
	endfunction

	function automatic logic signed [hvt_pkg::DATA_W-1:0] rand_fx();
		case ($urandom_range(0, 9))
			0, 1: return $urandom;
			2: begin
				case ($urandom_range(0, 4))
					0: return hvt_pkg::SAT_MAX;
					1: return hvt_pkg::SAT_MIN;
					2: return hvt_pkg::FX_ONE;
					3: return -hvt_pkg::FX_ONE;
					default: return '0;
				endcase
			end
			default: return $urandom_range(0, 1 << 20) - (1 << 19);
		endcase
	endfunction

	function automatic hvt_pkg::vtx_word_t write_word(int idx,
			logic signed [hvt_pkg::DATA_W-1:0] val);
		hvt_pkg::vtx_word_t w;
		w.opcode        = hvt_pkg::OP_WRITE;
		w.element_index = hvt_pkg::IDX_W'(idx);
		w.element_value = val;
		w.coord_x       = $urandom;
		w.coord_y       = $urandom;
		w.coord_z       = $urandom;
		return w;
	endfunction

	function automatic hvt_pkg::vtx_word_t point_word(logic signed [hvt_pkg::DATA_W-1:0] x,
			logic signed [hvt_pkg::DATA_W-1:0] y, logic signed [hvt_pkg::DATA_W-1:0] z);
		hvt_pkg::vtx_word_t w;
		w.opcode        = hvt_pkg::OP_XFORM;
		w.element_index = hvt_pkg::IDX_W'($urandom_range(0, hvt_pkg::ENTRIES - 1));
		w.element_value = $urandom;
		w.coord_x       = x;
		w.coord_y       = y;
		w.coord_z       = z;
		return w;
	endfunction

	task automatic send_word(hvt_pkg::vtx_word_t w);
		int gap;
		gap = quiet ? 0 : (($urandom_range(0, 99) < 35) ? idle_len() : 0);
		if (gap > 0) begin
			vtx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vtx_valid <= 1'b1;
		vtx       <= w;
		@(posedge clk);
		while (!vtx_ready) @(posedge clk);
		board.note_word(w);
	endtask

	task automatic drain();
		vtx_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int stall_left;
		int hold_seen;
		stall_left = 0;
		hold_seen  = 0;
		forever begin
			@(posedge clk);
			if (res_valid && res_ready)
				board.check_result(res);
			if (hold_reqs != hold_seen) begin
				hold_seen  = hold_reqs;
				stall_left = 80;
			end
			if (stall_left > 0) begin
				res_ready <= 1'b0;
				stall_left--;
			end else begin
				res_ready <= 1'b1;
				if (!quiet && $urandom_range(0, 99) < 30)
					stall_left = idle_len();
			end
		end
	end

	initial begin
		board = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send_word(point_word(hvt_pkg::SAT_MAX, hvt_pkg::SAT_MIN, 0));
		send_word(point_word(-1, 1, hvt_pkg::FX_ONE));
		send_word(write_word(12, hvt_pkg::SAT_MAX));
		send_word(point_word(hvt_pkg::FX_ONE, 0, 0));
		send_word(write_word(12, hvt_pkg::SAT_MIN));
		send_word(point_word(-hvt_pkg::FX_ONE, 0, 0));
		send_word(write_word(12, 0));
		send_word(write_word(0, 1));
		// tiny negative product floors to -1
		send_word(point_word(-1, 0, 0));
		send_word(point_word(1, 0, 0));
		send_word(write_word(0, hvt_pkg::SAT_MIN));
		send_word(point_word(hvt_pkg::SAT_MIN, 0, 0));
		send_word(write_word(5, hvt_pkg::SAT_MAX));
		send_word(point_word(0, hvt_pkg::SAT_MAX, 0));
		send_word(write_word(10, hvt_pkg::SAT_MIN));
		send_word(point_word(0, 0, hvt_pkg::SAT_MAX));
		send_word(write_word(15, hvt_pkg::SAT_MIN));
		send_word(write_word(3, hvt_pkg::SAT_MAX));
		send_word(point_word(hvt_pkg::SAT_MAX, hvt_pkg::SAT_MAX, hvt_pkg::SAT_MAX));
		send_word(point_word(hvt_pkg::SAT_MIN, hvt_pkg::SAT_MIN, hvt_pkg::SAT_MIN));
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			quiet <= (phase == 1 || phase == 3);
			if (phase == 3)
				hold_reqs <= hold_reqs + 1;
			for (int n = 0; n < 250; n++) begin
				if ($urandom_range(0, 99) < 20)
					send_word(write_word($urandom_range(0, hvt_pkg::ENTRIES - 1), rand_fx()));
				else
					send_word(point_word(rand_fx(), rand_fx(), rand_fx()));
			end
			drain();
		end

		if (board.mismatches == 0)
			$display("homogeneous_vertex_transform_tb: clean");
		else
			$display("homogeneous_vertex_transform_tb: errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("homogeneous_vertex_transform_tb: errors");
		$finish;
	end

endmodule
